FILE: hdl/rx_ring_page_reader_unit_assert.svh
// ---------------------------------------------------------------------------
// rx ring page reader assertion macros
// shared property wrappers for the block's checkers
// ---------------------------------------------------------------------------
`ifndef RX_RING_PAGE_READER_UNIT_ASSERT_SVH
`define RX_RING_PAGE_READER_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define RRPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// condition must never be seen outside reset
`define RRPR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: hdl/rrpr_pkg.sv
// ---------------------------------------------------------------------------
// rx ring page reader package
// verdict codes, register indexes and stream field widths
// ---------------------------------------------------------------------------
package rrpr_pkg;

  // result verdict codes
  typedef enum logic [2:0] {
    VERDICT_BAD      = 3'd0,
    VERDICT_EMPTY    = 3'd1,
    VERDICT_GOOD     = 3'd2,
    VERDICT_SHORT    = 3'd3,
    VERDICT_OVERSIZE = 3'd4,
    VERDICT_RXERR    = 3'd5
  } verdict_e;

  // configuration register indexes
  localparam logic [2:0] REG_RAM_BASE   = 3'd0;
  localparam logic [2:0] REG_RING_START = 3'd1;
  localparam logic [2:0] REG_RING_STOP  = 3'd2;
  localparam logic [2:0] REG_MIN_LEN    = 3'd3;
  localparam logic [2:0] REG_MAX_LEN    = 3'd4;

  // register reset values
  localparam logic [7:0]  RAM_BASE_RST   = 8'd32;
  localparam logic [7:0]  RING_START_RST = 8'd6;
  localparam logic [7:0]  RING_STOP_RST  = 8'd32;
  localparam logic [15:0] MIN_LEN_RST    = 16'd60;
  localparam logic [15:0] MAX_LEN_RST    = 16'd1514;

  // stream widths
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 144;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // header offset of frame data within a page, crc length
  localparam logic [7:0]  HDR_BYTES = 8'h04;
  localparam logic [15:0] CRC_BYTES = 16'd4;

endpackage

FILE: hdl/rx_ring_page_reader_unit.sv
// An accepted item is held in the input register and then in the result register.
// Throughput: one item per cycle while the sink is ready; a stalled full result register
// blocks an occupied input register; both stages advance together when the sink is ready.
// Reset: asynchronous, active low; clears valid flags and statistics counters and loads
// the ring configuration registers with their default page and length values.
// ---------------------------------------------------------------------------
// rx ring page reader
// receive ring read pointer logic: request check, empty ring detection,
// frame classification, wrap-split copy lengths, boundary update, counters
// ---------------------------------------------------------------------------
module rx_ring_page_reader_unit
  import rrpr_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input item stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // current_page_raw, boundary_page_raw, header_status, header_next_page,
  // header_count_low, header_count_high, buffer_len
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // result item stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // frame_len, copy_addr, first_len, second_len, new_boundary_raw,
  // boundary_write, drop_total, short_total, oversize_total, good_total, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // verdict
  output logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned ExtW = COUNTER_WIDTH + 16;

  // configuration registers
  logic [7:0]  ram_base_q, ring_start_q, ring_stop_q;
  logic [15:0] min_len_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q   <= RAM_BASE_RST;
      ring_start_q <= RING_START_RST;
      ring_stop_q  <= RING_STOP_RST;
      min_len_q    <= MIN_LEN_RST;
      max_len_q    <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RAM_BASE:   ram_base_q   <= cfg_data_i[7:0];
        REG_RING_START: ring_start_q <= cfg_data_i[7:0];
        REG_RING_STOP:  ring_stop_q  <= cfg_data_i[7:0];
        REG_MIN_LEN:    min_len_q    <= cfg_data_i;
        REG_MAX_LEN:    max_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  logic                 in_valid_q, out_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                 out_load, advance;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_load;
  assign s_axis_tready_o = !in_valid_q || out_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // input fields
  logic [7:0]  cur_raw, bnd_raw, hdr_status, hdr_next, cnt_lo, cnt_hi;
  logic [15:0] buf_len;

  assign cur_raw    = in_data_q[7:0];
  assign bnd_raw    = in_data_q[15:8];
  assign hdr_status = in_data_q[23:16];
  assign hdr_next   = in_data_q[31:24];
  assign cnt_lo     = in_data_q[39:32];
  assign cnt_hi     = in_data_q[47:40];
  assign buf_len    = in_data_q[63:48];

  // statistics counters
  logic [COUNTER_WIDTH-1:0] drop_q, short_q, over_q, good_q;
  logic [COUNTER_WIDTH-1:0] drop_d, short_d, over_d, good_d;

  // classification and copy split
  verdict_e     verdict;
  logic         bad_req, empty_ring, is_short, is_over, wrap, bwrite;
  logic [7:0]   cur_rel, read_pg0, read_pg, next_rel, nb_rel, nb_raw;
  logic [15:0]  count, rlen, flen, copy_addr, first_len, second_len;
  logic [8:0]   pg_diff;
  logic signed [17:0] clen;

  always_comb begin
    verdict    = VERDICT_BAD;
    flen       = '0;
    copy_addr  = '0;
    first_len  = '0;
    second_len = '0;
    nb_raw     = bnd_raw;
    bwrite     = 1'b0;
    drop_d     = drop_q;
    short_d    = short_q;
    over_d     = over_q;
    good_d     = good_q;

    // request check against signed buffer length
    bad_req = buf_len[15] || (buf_len == 16'd0) || ({1'b0, buf_len[14:0]} > max_len_q);

    // ring pages relative to ram base
    cur_rel  = cur_raw - ram_base_q;
    read_pg0 = bnd_raw - ram_base_q + 8'd1;
    read_pg  = (read_pg0 >= ring_stop_q) ? ring_start_q : read_pg0;
    empty_ring = (read_pg == cur_rel);

    // length checks
    count    = {cnt_hi, cnt_lo};
    rlen     = count - CRC_BYTES;
    is_short = ({1'b0, count} < ({1'b0, min_len_q} + {1'b0, CRC_BYTES}));
    is_over  = (rlen > max_len_q) || (rlen > buf_len);

    // wrap split: space left before ring end
    wrap    = ({1'b0, read_pg} + {1'b0, cnt_hi}) >= {1'b0, ring_stop_q};
    pg_diff = {1'b0, ring_stop_q} - {1'b0, read_pg};
    clen    = $signed({pg_diff[8], pg_diff, 8'h00}) - 18'sd4;

    // new boundary one page behind the next frame
    next_rel = hdr_next - ram_base_q;
    nb_rel   = next_rel - 8'd1;
    if (nb_rel < ring_start_q) begin
      nb_rel = ring_stop_q - 8'd1;
    end

    if (!bad_req) begin
      if (empty_ring) begin
        verdict = VERDICT_EMPTY;
      end else begin
        bwrite = 1'b1;
        nb_raw = nb_rel + ram_base_q;
        if (!hdr_status[0]) begin
          verdict = VERDICT_RXERR;
          drop_d  = drop_q + 1'b1;
        end else if (is_short) begin
          verdict = VERDICT_SHORT;
          drop_d  = drop_q + 1'b1;
          short_d = short_q + 1'b1;
        end else if (is_over) begin
          verdict = VERDICT_OVERSIZE;
          drop_d  = drop_q + 1'b1;
          over_d  = over_q + 1'b1;
        end else begin
          verdict   = VERDICT_GOOD;
          good_d    = good_q + 1'b1;
          flen      = rlen;
          copy_addr = {read_pg, HDR_BYTES};
          if (wrap && (clen < $signed({2'b00, rlen}))) begin
            first_len  = clen[17] ? 16'd0 : clen[15:0];
            second_len = rlen - first_len;
          end else begin
            first_len = rlen;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q  <= '0;
      short_q <= '0;
      over_q  <= '0;
      good_q  <= '0;
    end else if (advance) begin
      drop_q  <= drop_d;
      short_q <= short_d;
      over_q  <= over_d;
      good_q  <= good_d;
    end
  end

  // counter totals, low 16 bits
  logic [ExtW-1:0] drop_ext, short_ext, over_ext, good_ext;

  assign drop_ext  = {16'd0, drop_d};
  assign short_ext = {16'd0, short_d};
  assign over_ext  = {16'd0, over_d};
  assign good_ext  = {16'd0, good_d};

  // result register
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_user_q <= verdict;
      out_data_q <= {7'd0, good_ext[15:0], over_ext[15:0], short_ext[15:0],
                     drop_ext[15:0], bwrite, nb_raw, second_len, first_len,
                     copy_addr, flen};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

FILE: hdl/rrpr_checker.sv
// ---------------------------------------------------------------------------
// rx ring page reader checker
// port-level checks on result items, bound to the top level
// ---------------------------------------------------------------------------
`include "rx_ring_page_reader_unit_assert.svh"

module rrpr_checker
  import rrpr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  logic        is_good, is_bad, is_empty;
  logic [16:0] split_sum;

  assign is_good   = (m_axis_tuser_o == VERDICT_GOOD);
  assign is_bad    = (m_axis_tuser_o == VERDICT_BAD);
  assign is_empty  = (m_axis_tuser_o == VERDICT_EMPTY);
  assign split_sum = {1'b0, m_axis_tdata_o[47:32]} + {1'b0, m_axis_tdata_o[63:48]};

  // stalled result item holds
  `RRPR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result item changed")

  // boundary write exactly for frame verdicts
  `RRPR_ASSERT(a_bwrite, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[72] == !(is_bad || is_empty)), "boundary write flag disagrees with verdict")

  // copy fields are zero unless the frame is good
  `RRPR_ASSERT_NEVER(a_copy_zero, clk_i, rst_ni, m_axis_tvalid_o && !is_good && (m_axis_tdata_o[63:0] != 64'd0), "copy fields set on a non-good item")

  // split lengths add up to the frame length
  `RRPR_ASSERT(a_split_sum, clk_i, rst_ni, m_axis_tvalid_o && is_good |-> (split_sum == {1'b0, m_axis_tdata_o[15:0]}), "copy split does not cover the frame")

endmodule

bind rx_ring_page_reader_unit rrpr_checker u_rrpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
